// ===== hdl/vbd_pkg.sv =====
package vbd_pkg;

    // Configuration port
    localparam int CFG_W = 9;
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_BLOCKS_WIDE = 1'b0;
    localparam t_cfg_idx REG_BLOCKS_HIGH = 1'b1;

    localparam logic [CFG_W-1:0] BLOCKS_WIDE_RST = 9'd80;
    localparam logic [CFG_W-1:0] BLOCKS_HIGH_RST = 9'd50;

    // Frame size limits (defaults of the top level parameters)
    localparam int MAX_BLOCKS_WIDE_DEF = 256;
    localparam int MAX_BLOCKS_HIGH_DEF = 256;

    // Code word decoding
    localparam int         SKIP_W    = 10;
    localparam logic [7:0] SKIP_MASK = 8'hFC;
    localparam logic [7:0] SKIP_CODE = 8'h84;
    localparam logic [7:0] FILL_MIN  = 8'h80;
    localparam logic [15:0] QUAD_BIT = 16'h8000;

    localparam int POS_OUT_W = 10;

    // Block queue: 2**QUEUE_AW entries
    localparam int QUEUE_AW = 1;

    // One finished block, ready to be written out row by row
    typedef struct packed {
        logic [POS_OUT_W-1:0] base_row;  // memory row of pixel row 0
        logic [POS_OUT_W-1:0] col;       // first pixel column
        logic [15:0]          flags;
        logic [7:0][15:0]     colours;   // index {quad_row, quad_col, pick_second}
    } t_blk;

endpackage

// ===== hdl/vbd_word_if.sv =====
interface vbd_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_word;
    logic        chunk_end;

    modport source (output valid, output code_word, output chunk_end, input ready);
    modport sink   (input valid, input code_word, input chunk_end, output ready);
endinterface

// ===== hdl/vbd_row_if.sv =====
interface vbd_row_if;
    logic        valid;
    logic        ready;
    logic [9:0]  image_row;
    logic [9:0]  image_col;
    logic [15:0] pixel_a;
    logic [15:0] pixel_b;
    logic [15:0] pixel_c;
    logic [15:0] pixel_d;
    logic        block_last_row;

    modport source (
        output valid, output image_row, output image_col,
        output pixel_a, output pixel_b, output pixel_c, output pixel_d,
        output block_last_row, input ready
    );
    modport sink (
        input valid, input image_row, input image_col,
        input pixel_a, input pixel_b, input pixel_c, input pixel_d,
        input block_last_row, output ready
    );
endinterface

// ===== hdl/vbd_div.sv =====
module vbd_div #(
    parameter int DVD_W = 11,
    parameter int DVS_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_quot, n_quot;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // one quotient bit per cycle, restoring
    assign w_shift = {r_rem, r_quot[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W);
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[DVD_W-2:0], w_ge};
            n_rem  = w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/vbd_queue.sv =====
module vbd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vbd_pkg::t_blk i_blk,
    output logic          o_full,
    output logic          o_valid,
    output vbd_pkg::t_blk o_head,
    input  logic          i_pop
);
    import vbd_pkg::*;

    localparam int DEPTH = 2 ** QUEUE_AW;

    t_blk              r_mem [DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_blk;
        end
    end

endmodule

// ===== hdl/vbd_front.sv =====
module vbd_front #(
    parameter int MAX_BLOCKS_WIDE = vbd_pkg::MAX_BLOCKS_WIDE_DEF,
    parameter int MAX_BLOCKS_HIGH = vbd_pkg::MAX_BLOCKS_HIGH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [vbd_pkg::CFG_W-1:0]  i_blocks_wide,
    input  logic [vbd_pkg::CFG_W-1:0]  i_blocks_high,
    vbd_word_if.sink                   i_word,
    input  logic                       i_q_full,
    output logic                       o_push,
    output vbd_pkg::t_blk              o_blk
);
    import vbd_pkg::*;

    localparam int WID_W  = $clog2(MAX_BLOCKS_WIDE + 1);
    localparam int HGT_W  = $clog2(MAX_BLOCKS_HIGH + 1);
    localparam int POS_W  = ((WID_W > SKIP_W) ? WID_W : SKIP_W) + 1;
    localparam int SUM_W  = ((HGT_W > POS_W) ? HGT_W : POS_W) + 1;
    localparam int CWW    = (WID_W > CFG_W) ? WID_W : CFG_W;
    localparam int CHW    = (HGT_W > CFG_W) ? HGT_W : CFG_W;
    localparam int COLX_W = (WID_W > 8) ? WID_W : 8;
    localparam int ROWX_W = (HGT_W > 8) ? HGT_W : 8;

    typedef enum logic {ST_RUN, ST_DIV} t_state;

    typedef enum logic [3:0] {
        PH_CODE = 4'd0,
        PH_C0   = 4'd1,
        PH_C1   = 4'd2,
        PH_C2   = 4'd3,
        PH_C3   = 4'd4,
        PH_C4   = 4'd5,
        PH_C5   = 4'd6,
        PH_C6   = 4'd7,
        PH_C7   = 4'd8
    } t_phase;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic                r_hold_v, n_hold_v;
    logic [15:0]         r_word, n_word;
    logic                r_end, n_end;
    logic [15:0]         r_flags, n_flags;
    logic [15:0]         r_cs [8];
    logic [15:0]         n_cs [8];
    logic [WID_W-1:0]    r_col, n_col;
    logic [HGT_W-1:0]    r_row, n_row;
    logic [SKIP_W-1:0]   r_skip, n_skip;
    logic                r_stopped, n_stopped;

    logic [WID_W-1:0]    eff_w;
    logic [HGT_W-1:0]    eff_h;
    logic [CWW-1:0]      wide_x;
    logic [CHW-1:0]      high_x;
    logic                need_div;
    logic                row_over;
    logic                is_skip;
    logic                will_emit;
    logic                consume;
    logic                step;
    logic [2:0]          cs_idx;
    logic                div_start;
    logic                div_done;
    logic [POS_W-1:0]    div_quot;
    logic [WID_W-1:0]    div_rem;
    logic [POS_W-1:0]    div_dvd;
    logic [SUM_W-1:0]    row_sum;
    logic [COLX_W-1:0]   col_x;
    logic [ROWX_W-1:0]   rows_left;
    t_blk                blk;

    // clamp the frame size to 1..max
    assign wide_x = CWW'(i_blocks_wide);
    assign high_x = CHW'(i_blocks_high);
    always_comb begin
        if (i_blocks_wide == '0) begin
            eff_w = WID_W'(1);
        end else if (wide_x > CWW'(MAX_BLOCKS_WIDE)) begin
            eff_w = WID_W'(MAX_BLOCKS_WIDE);
        end else begin
            eff_w = WID_W'(wide_x);
        end
        if (i_blocks_high == '0) begin
            eff_h = HGT_W'(1);
        end else if (high_x > CHW'(MAX_BLOCKS_HIGH)) begin
            eff_h = HGT_W'(MAX_BLOCKS_HIGH);
        end else begin
            eff_h = HGT_W'(high_x);
        end
    end

    // pending skip or a column past a narrowed width needs the divider
    assign need_div = !r_stopped && ((r_skip != '0) || (r_col >= eff_w));
    assign row_over = (r_row >= eff_h);
    assign is_skip  = ((r_word[15:8] & SKIP_MASK) == SKIP_CODE);
    assign cs_idx   = 3'(4'(r_phase) - 4'd1);

    always_comb begin
        will_emit = 1'b0;
        if (!r_stopped && !row_over) begin
            case (r_phase)
                PH_CODE: will_emit = !is_skip && (r_word[15:8] >= FILL_MIN);
                PH_C1:   will_emit = ((r_cs[0] & QUAD_BIT) == '0);
                PH_C7:   will_emit = 1'b1;
                default: will_emit = 1'b0;
            endcase
        end
    end

    // block descriptor
    assign col_x     = COLX_W'(r_col);
    assign rows_left = ROWX_W'(eff_h) - ROWX_W'(r_row);
    always_comb begin
        blk.base_row = {rows_left[7:0], 2'b00} - POS_OUT_W'(1);
        blk.col      = {col_x[7:0], 2'b00};
        blk.flags    = r_flags;
        for (int i = 0; i < 8; i++) begin
            case (r_phase)
                PH_CODE: blk.colours[i] = r_word;
                PH_C1:   blk.colours[i] = (i % 2 == 1) ? r_word : r_cs[0];
                default: blk.colours[i] = (i == 7) ? r_word : r_cs[i];
            endcase
        end
    end

    assign div_dvd = POS_W'(r_col) + POS_W'(r_skip);
    assign row_sum = SUM_W'(r_row) + SUM_W'(div_quot);

    // word processing
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_hold_v  = r_hold_v;
        n_word    = r_word;
        n_end     = r_end;
        n_flags   = r_flags;
        n_cs      = r_cs;
        n_col     = r_col;
        n_row     = r_row;
        n_skip    = r_skip;
        n_stopped = r_stopped;
        div_start = 1'b0;
        consume   = 1'b0;
        step      = 1'b0;
        o_push    = 1'b0;

        case (r_state)
            ST_RUN: begin
                if (r_hold_v) begin
                    if (need_div) begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end else if (!(will_emit && i_q_full)) begin
                        consume = 1'b1;
                        o_push  = will_emit;
                        if (!r_stopped && row_over) begin
                            n_stopped = 1'b1;
                        end else if (!r_stopped) begin
                            case (r_phase)
                                PH_CODE: begin
                                    if (is_skip) begin
                                        if (r_word[SKIP_W-1:0] == '0) begin
                                            n_stopped = 1'b1;
                                        end else begin
                                            n_skip = r_word[SKIP_W-1:0] - SKIP_W'(1);
                                            step   = 1'b1;
                                        end
                                    end else if (r_word[15:8] < FILL_MIN) begin
                                        n_flags = r_word;
                                        n_phase = PH_C0;
                                    end else begin
                                        step = 1'b1;
                                    end
                                end
                                PH_C0: begin
                                    n_cs[0] = r_word;
                                    n_phase = PH_C1;
                                end
                                PH_C1: begin
                                    n_cs[1] = r_word;
                                    if (will_emit) begin
                                        step    = 1'b1;
                                        n_phase = PH_CODE;
                                    end else begin
                                        n_phase = PH_C2;
                                    end
                                end
                                PH_C2, PH_C3, PH_C4, PH_C5, PH_C6: begin
                                    n_cs[cs_idx] = r_word;
                                    n_phase      = t_phase'(4'(r_phase) + 4'd1);
                                end
                                PH_C7: begin
                                    n_cs[7] = r_word;
                                    step    = 1'b1;
                                    n_phase = PH_CODE;
                                end
                                default: n_phase = PH_CODE;
                            endcase

                            // move on one block
                            if (step) begin
                                if (r_col + WID_W'(1) == eff_w) begin
                                    n_col = '0;
                                    if (r_row + HGT_W'(1) == eff_h) begin
                                        n_stopped = 1'b1;
                                    end else begin
                                        n_row = r_row + HGT_W'(1);
                                    end
                                end else begin
                                    n_col = r_col + WID_W'(1);
                                end
                            end
                        end

                        // chunk end restarts the frame
                        if (r_end) begin
                            n_phase   = PH_CODE;
                            n_flags   = '0;
                            n_col     = '0;
                            n_row     = '0;
                            n_skip    = '0;
                            n_stopped = 1'b0;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_col  = div_rem;
                    n_skip = '0;
                    if (row_sum >= SUM_W'(eff_h)) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_row = HGT_W'(row_sum);
                    end
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase

        // input beat
        if (consume) begin
            n_hold_v = 1'b0;
        end
        if (i_word.valid && (!r_hold_v || consume)) begin
            n_hold_v = 1'b1;
            n_word   = i_word.code_word;
            n_end    = i_word.chunk_end;
        end
    end

    assign i_word.ready = !r_hold_v || consume;
    assign o_blk        = blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_phase   <= PH_CODE;
            r_hold_v  <= 1'b0;
            r_flags   <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_skip    <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_hold_v  <= n_hold_v;
            r_flags   <= n_flags;
            r_col     <= n_col;
            r_row     <= n_row;
            r_skip    <= n_skip;
            r_stopped <= n_stopped;
        end
        r_word <= n_word;
        r_end  <= n_end;
        r_cs   <= n_cs;
    end

    vbd_div #(
        .DVD_W (POS_W),
        .DVS_W (WID_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (eff_w),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

`ifndef NO_ASSERTIONS
    // no block leaves while the position is being recomputed
    a_no_push_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !o_push)
        else $error("block pushed during position divide");

    // a chunk end leaves a clean frame
    a_chunk_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_end) |=> (r_phase == PH_CODE && !r_stopped && r_skip == '0
                                && r_col == '0 && r_row == '0))
        else $error("frame state not cleared after chunk end");

    // blocks are only placed inside the frame
    a_push_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (!r_stopped && r_row < eff_h && r_col < eff_w))
        else $error("block pushed outside the frame");

    // the held word survives the divide
    a_hold_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && div_done) |=> (r_state == ST_RUN && r_hold_v && !need_div))
        else $error("held word lost across divide");
`endif

endmodule

// ===== hdl/vbd_back.sv =====
module vbd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  vbd_pkg::t_blk i_head,
    output logic          o_pop,
    vbd_row_if.source     o_row
);
    import vbd_pkg::*;

    logic [1:0]  r_py;
    logic        r_ov;
    logic [9:0]  r_img_row;
    logic [9:0]  r_img_col;
    logic [15:0] r_pix_a, r_pix_b, r_pix_c, r_pix_d;
    logic        r_last;
    logic        load;
    logic [3:0]  fr;

    function automatic logic [15:0] pick(t_blk b, logic hi_row, logic hi_col, logic flag);
        return b.colours[{hi_row, hi_col, ~flag}];
    endfunction

    // next row goes out when the output register is free or drains now
    assign load  = i_q_valid && (!r_ov || o_row.ready);
    assign o_pop = load && (r_py == 2'd3);
    assign fr    = i_head.flags[{r_py, 2'b00} +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_py <= '0;
            r_ov <= 1'b0;
        end else begin
            if (load) begin
                r_py <= r_py + 2'd1;
                r_ov <= 1'b1;
            end else if (o_row.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (load) begin
            r_img_row <= i_head.base_row - POS_OUT_W'(r_py);
            r_img_col <= i_head.col;
            r_pix_a   <= pick(i_head, r_py[1], 1'b0, fr[0]);
            r_pix_b   <= pick(i_head, r_py[1], 1'b0, fr[1]);
            r_pix_c   <= pick(i_head, r_py[1], 1'b1, fr[2]);
            r_pix_d   <= pick(i_head, r_py[1], 1'b1, fr[3]);
            r_last    <= (r_py == 2'd3);
        end
    end

    assign o_row.valid          = r_ov;
    assign o_row.image_row      = r_img_row;
    assign o_row.image_col      = r_img_col;
    assign o_row.pixel_a        = r_pix_a;
    assign o_row.pixel_b        = r_pix_b;
    assign o_row.pixel_c        = r_pix_c;
    assign o_row.pixel_d        = r_pix_d;
    assign o_row.block_last_row = r_last;

endmodule

// ===== hdl/video1_block_decoder.sv =====
// Channel   Dir  Beat                         Payload
// i_word    in   one 16-bit frame word        code_word, chunk_end
// o_row     out  one 4-pixel row of a block   image_row, image_col, pixel_a..d,
//                                             block_last_row
// i_cfg_*   in   register write               i_cfg_idx, i_cfg_data
//
// Words enter at one per cycle unless a divide is running or a finished
// block finds the block queue full; a finished block leaves as four row
// beats, so a stream of fill words is paced by the row output register. A
// pending skip count or a column past a narrowed width costs a restoring
// divide before the word is decoded. Reset is synchronous; the size
// registers return to 80 x 50 and no clearing pass is needed. The two-block
// queue lets word intake continue while the output side is stalled.
module video1_block_decoder #(
    parameter int MAX_BLOCKS_WIDE = vbd_pkg::MAX_BLOCKS_WIDE_DEF,
    parameter int MAX_BLOCKS_HIGH = vbd_pkg::MAX_BLOCKS_HIGH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  vbd_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [vbd_pkg::CFG_W-1:0] i_cfg_data,
    vbd_word_if.sink                  i_word,
    vbd_row_if.source                 o_row
);
    import vbd_pkg::*;

    logic [CFG_W-1:0] r_blocks_wide;
    logic [CFG_W-1:0] r_blocks_high;
    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_blk             q_in;
    t_blk             q_head;

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_wide <= BLOCKS_WIDE_RST;
            r_blocks_high <= BLOCKS_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCKS_WIDE: r_blocks_wide <= i_cfg_data;
                REG_BLOCKS_HIGH: r_blocks_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vbd_front #(
        .MAX_BLOCKS_WIDE (MAX_BLOCKS_WIDE),
        .MAX_BLOCKS_HIGH (MAX_BLOCKS_HIGH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_blocks_wide (r_blocks_wide),
        .i_blocks_high (r_blocks_high),
        .i_word        (i_word),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_blk         (q_in)
    );

    vbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_blk   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    vbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_row     (o_row)
    );

endmodule

// ===== tb/video1_block_decoder_test.sv =====
`timescale 1ns / 1ps

module video1_block_decoder_test;
    import vbd_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES = 40;    // covers the skip divide and the row pipe
    localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
    localparam int RANDOM_WORDS  = 80;

    // Word decode phases
    localparam int unsigned PH_CODE       = 0;
    localparam int unsigned PH_COLOUR_A   = 1;
    localparam int unsigned PH_COLOUR_B   = 2;
    localparam int unsigned PH_QUAD_FIRST = 3;
    localparam int unsigned PH_QUAD_LAST  = 8;

    typedef enum {PAINT_FILL, PAINT_TWO, PAINT_EIGHT} t_paint;
    typedef enum {BLK_FILL, BLK_TWO, BLK_EIGHT, BLK_SKIP, BLK_NOISE} t_blk_kind;

    typedef struct packed {
        logic [9:0]  image_row;
        logic [9:0]  image_col;
        logic [15:0] pixel_a;
        logic [15:0] pixel_b;
        logic [15:0] pixel_c;
        logic [15:0] pixel_d;
        logic        block_last_row;
    } t_pix_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    t_cfg_idx       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    vbd_word_if word_ch();
    vbd_row_if  row_ch();

    video1_block_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_word     (word_ch),
        .o_row      (row_ch)
    );

    // Decoder state as predicted
    logic [8:0]     size_wide;
    logic [8:0]     size_high;
    int unsigned    dec_phase;
    int unsigned    dec_flags;
    logic [15:0]    dec_colours [8];
    int unsigned    dec_col;
    int unsigned    dec_row;
    int unsigned    dec_skip;
    bit             dec_stopped;

    t_pix_row       rows_due [$];

    int             fail_count;
    int             words_sent;
    int             rows_seen;
    int             reg_writes;
    int             stall_count;
    bit             tx_idle;
    bit             rx_idle;
    int             rx_hold_req;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int unsigned clamp_size(logic [8:0] v, int unsigned lim);
        int unsigned s;
        s = v;
        if (s < 1) s = 1;
        if (s > lim) s = lim;
        return s;
    endfunction

    function automatic void restart_frame();
        dec_phase   = PH_CODE;
        dec_flags   = 0;
        dec_col     = 0;
        dec_row     = 0;
        dec_skip    = 0;
        dec_stopped = 1'b0;
    endfunction

    // Move k blocks on; running off the last block row ends the frame
    function automatic void step_position(int unsigned k);
        int unsigned w, h, pos, r;
        w = clamp_size(size_wide, MAX_BLOCKS_WIDE_DEF);
        h = clamp_size(size_high, MAX_BLOCKS_HIGH_DEF);
        pos = dec_col + k;
        r = dec_row + pos / w;
        dec_col = pos % w;
        if (r >= h) begin
            r = h;
            dec_stopped = 1'b1;
        end
        dec_row = r;
    endfunction

    // Four pixel rows of the current block, highest memory row first
    function automatic void paint_block(t_paint mode, logic [15:0] colour);
        int unsigned h, flags, sel, mem_row, col_px;
        logic [15:0] px_val [4];
        t_pix_row r;
        h = clamp_size(size_high, MAX_BLOCKS_HIGH_DEF);
        flags = dec_flags;
        for (int unsigned py = 0; py < 4; py++) begin
            mem_row = 4 * (h - dec_row) - 1 - py;
            col_px  = 4 * dec_col;
            for (int unsigned px = 0; px < 4; px++) begin
                sel = (flags & 1) ^ 1;
                case (mode)
                    PAINT_FILL: px_val[px] = colour;
                    PAINT_TWO:  px_val[px] = dec_colours[sel];
                    default:    px_val[px] = dec_colours[(((py & 2) << 1) + (px & 2) + sel) & 7];
                endcase
                flags = flags >> 1;
            end
            r.image_row      = mem_row[9:0];
            r.image_col      = col_px[9:0];
            r.pixel_a        = px_val[0];
            r.pixel_b        = px_val[1];
            r.pixel_c        = px_val[2];
            r.pixel_d        = px_val[3];
            r.block_last_row = (py == 3);
            rows_due.push_back(r);
        end
        step_position(1);
    endfunction

    function automatic void predict_rows(logic [15:0] w, logic end_of_chunk);
        int unsigned k, cnt;
        if (!dec_stopped) begin
            k = dec_skip;
            dec_skip = 0;
            step_position(k);
        end
        if (!dec_stopped) begin
            case (dec_phase)
                PH_CODE: begin
                    if ((w[15:8] & SKIP_MASK) == SKIP_CODE) begin
                        cnt = w[SKIP_W-1:0];
                        if (cnt == 0) begin
                            dec_stopped = 1'b1;
                        end else begin
                            dec_skip = cnt - 1;
                            step_position(1);
                        end
                    end else if (w[15:8] < FILL_MIN) begin
                        dec_flags = w;
                        dec_phase = PH_COLOUR_A;
                    end else begin
                        paint_block(PAINT_FILL, w);
                    end
                end
                PH_COLOUR_A: begin
                    dec_colours[0] = w;
                    dec_phase = PH_COLOUR_B;
                end
                PH_COLOUR_B: begin
                    dec_colours[1] = w;
                    if ((dec_colours[0] & QUAD_BIT) != 0) begin
                        dec_phase = PH_QUAD_FIRST;
                    end else begin
                        paint_block(PAINT_TWO, 16'h0000);
                        dec_phase = PH_CODE;
                    end
                end
                default: begin
                    dec_colours[(dec_phase - 1) & 7] = w;
                    if (dec_phase == PH_QUAD_LAST) begin
                        paint_block(PAINT_EIGHT, 16'h0000);
                        dec_phase = PH_CODE;
                    end else begin
                        dec_phase++;
                    end
                end
            endcase
        end
        if (end_of_chunk) restart_frame();
    endfunction

    // ---------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------
    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_word();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [15:0] rand_fill();
        logic [15:0] w;
        do begin
            w = 16'($urandom_range(16'h8000, 16'hFFFF));
        end while ((w[15:8] & SKIP_MASK) == SKIP_CODE);
        return w;
    endfunction

    function automatic logic [15:0] rand_skip();
        int r;
        logic [9:0] cnt;
        r = $urandom_range(0, 99);
        if (r < 10) cnt = '0;
        else if (r < 20) cnt = 10'($urandom_range(5, 1023));
        else cnt = 10'($urandom_range(1, 4));
        return {SKIP_CODE[7:2], cnt};
    endfunction

    // ---------------------------------------------------------------
    // Word sender: one beat per call, valid stays up into the next call
    // ---------------------------------------------------------------
    task automatic send_word(input logic [15:0] w, input logic end_of_chunk);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            word_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        word_ch.valid     = 1'b1;
        word_ch.code_word = w;
        word_ch.chunk_end = end_of_chunk;
        do @(posedge i_clk); while (!word_ch.ready);
        predict_rows(w, end_of_chunk);
        words_sent++;
    endtask

    // Stop offering words and let the block run dry
    task automatic settle_block();
        @(negedge i_clk);
        word_ch.valid = 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input t_cfg_idx idx, input int unsigned val);
        settle_block();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == REG_BLOCKS_WIDE) size_wide = val[8:0];
        else size_high = val[8:0];
        reg_writes++;
    endtask

    task automatic send_block(input t_blk_kind kind, input bit end_of_chunk, input bit cut);
        logic [15:0] words [$];
        int keep;
        case (kind)
            BLK_FILL: words.push_back(rand_fill());
            BLK_TWO: begin
                words.push_back(16'($urandom_range(0, 16'h7FFF)));
                words.push_back(16'($urandom_range(0, 16'h7FFF)));
                words.push_back(rand_word());
            end
            BLK_EIGHT: begin
                words.push_back(16'($urandom_range(0, 16'h7FFF)));
                words.push_back(rand_word() | QUAD_BIT);
                repeat (7) words.push_back(rand_word());
            end
            BLK_SKIP: words.push_back(rand_skip());
            default: words.push_back(rand_word());
        endcase
        // broken block: chunk ends part way through
        if (cut && words.size() > 1) begin
            keep = $urandom_range(1, words.size() - 1);
            while (words.size() > keep) void'(words.pop_back());
        end
        foreach (words[j])
            send_word(words[j], end_of_chunk && (j == words.size() - 1));
    endtask

    task automatic send_random_frame(input int n_blocks);
        int r;
        t_blk_kind kind;
        for (int i = 0; i < n_blocks; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) kind = BLK_FILL;
            else if (r < 55) kind = BLK_TWO;
            else if (r < 75) kind = BLK_EIGHT;
            else if (r < 88) kind = BLK_SKIP;
            else kind = BLK_NOISE;
            send_block(kind, i == n_blocks - 1,
                       (i == n_blocks - 1) && ($urandom_range(0, 5) == 0));
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Fill, two-colour and eight-colour blocks over a whole 3x2 frame
    task automatic test_block_kinds();
        write_size(REG_BLOCKS_WIDE, 3);
        write_size(REG_BLOCKS_HIGH, 2);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_word(16'h8000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h83FF, 1'b0);
        // all-zero flag word is a plain two-colour block
        send_word(16'h0000, 1'b0);
        send_word(16'h1234, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8001, 1'b0);
        repeat (7) send_word(rand_word(), 1'b0);
        send_word(16'h8800, 1'b0);
        // frame full: this word is ignored
        send_word(16'hFFFF, 1'b1);
    endtask

    task automatic test_skip_codes();
        send_word(16'h8401, 1'b0);
        send_word(rand_fill(), 1'b0);
        send_word(16'h8402, 1'b0);
        send_word(rand_fill(), 1'b0);      // pending skip applied first
        send_word(16'h8400, 1'b0);         // zero count ends the frame
        send_word(rand_fill(), 1'b1);
        send_word(16'h87FF, 1'b0);         // skip past the frame end
        send_word(rand_fill(), 1'b1);
    endtask

    task automatic test_chunk_end();
        send_word(16'h9234, 1'b1);         // block completed by the last word
        send_word(16'h00FF, 1'b0);
        send_word(16'h0101, 1'b1);         // incomplete block dropped
        send_word(16'h9234, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'h0F0F, 1'b0);
        send_word(16'hF0F0, 1'b1);
        send_word(16'h3333, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h1111, 1'b1);         // eight-colour block cut short
        send_word(rand_fill(), 1'b1);
    endtask

    // Size clamping and size changes in the middle of a frame
    task automatic test_register_limits();
        write_size(REG_BLOCKS_WIDE, 0);
        write_size(REG_BLOCKS_HIGH, 0);
        send_word(rand_fill(), 1'b0);
        send_word(rand_fill(), 1'b1);
        write_size(REG_BLOCKS_WIDE, 256);
        write_size(REG_BLOCKS_HIGH, 1);
        send_word(rand_fill(), 1'b1);
        write_size(REG_BLOCKS_WIDE, 511);
        write_size(REG_BLOCKS_HIGH, 511);
        send_word(rand_fill(), 1'b0);
        send_word(16'h84FE, 1'b0);
        send_word(rand_fill(), 1'b1);      // last column, top memory row
        write_size(REG_BLOCKS_HIGH, 256);
        send_word(rand_fill(), 1'b1);
        write_size(REG_BLOCKS_WIDE, 8);
        write_size(REG_BLOCKS_HIGH, 4);
        repeat (6) send_word(rand_fill(), 1'b0);
        // narrower frame: column 6 wraps into the next block row
        write_size(REG_BLOCKS_WIDE, 4);
        send_word(rand_fill(), 1'b0);
        // lower frame: current row is now past the end
        write_size(REG_BLOCKS_HIGH, 1);
        send_word(rand_fill(), 1'b1);
    endtask

    // Receiver holds off while words keep coming, so the block queue fills
    task automatic test_backpressure();
        write_size(REG_BLOCKS_WIDE, 8);
        write_size(REG_BLOCKS_HIGH, 8);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        for (int i = 0; i < 16; i++) send_word(rand_fill(), i == 15);
    endtask

    task automatic test_random_frames();
        int target;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            if ($urandom_range(0, 7) == 0) begin
                write_size(REG_BLOCKS_WIDE, $urandom_range(0, 511));
                write_size(REG_BLOCKS_HIGH, $urandom_range(0, 511));
            end else begin
                write_size(REG_BLOCKS_WIDE, $urandom_range(1, 12));
                write_size(REG_BLOCKS_HIGH, $urandom_range(1, 8));
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) send_random_frame($urandom_range(2, 12));
        end
    endtask

    // ---------------------------------------------------------------
    // Row receiver: random stalls plus requested hold-off
    // ---------------------------------------------------------------
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        row_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                row_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                row_ch.ready = 1'b0;
                stall_left--;
            end else begin
                stall_left = rx_idle ? pick_gap() : 0;
                row_ch.ready = (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // ---------------------------------------------------------------
    // Row checker
    // ---------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : row_check
        t_pix_row exp_row;
        if (i_rst_n && row_ch.valid && row_ch.ready) begin
            rows_seen++;
            if (rows_due.size() == 0) begin
                $error("pixel row beat with nothing expected: row %0d col %0d",
                       row_ch.image_row, row_ch.image_col);
                fail_count++;
            end else begin
                exp_row = rows_due.pop_front();
                check_field("image_row", exp_row.image_row, row_ch.image_row);
                check_field("image_col", exp_row.image_col, row_ch.image_col);
                check_field("pixel_a", exp_row.pixel_a, row_ch.pixel_a);
                check_field("pixel_b", exp_row.pixel_b, row_ch.pixel_b);
                check_field("pixel_c", exp_row.pixel_c, row_ch.pixel_c);
                check_field("pixel_d", exp_row.pixel_d, row_ch.pixel_d);
                check_field("block_last_row", exp_row.block_last_row,
                            row_ch.block_last_row);
            end
        end
    end

    // Watchdog: too long without a beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (word_ch.valid && word_ch.ready) || (row_ch.valid && row_ch.ready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("Timeout: no beat for %0d cycles, %0d rows still due",
                         stall_count, rows_due.size());
                $display("FAIL video1_block_decoder");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_BLOCKS_WIDE;
        i_cfg_data        = '0;
        word_ch.valid     = 1'b0;
        word_ch.code_word = 16'h0000;
        word_ch.chunk_end = 1'b0;
        fail_count  = 0;
        words_sent  = 0;
        rows_seen   = 0;
        reg_writes  = 0;
        stall_count = 0;
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        rx_hold_req = 0;
        size_wide   = BLOCKS_WIDE_RST;
        size_high   = BLOCKS_HIGH_RST;
        for (int i = 0; i < 8; i++) dec_colours[i] = 16'h0000;
        restart_frame();

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // first frame at the reset size, 80 x 50
        tx_idle = 1'b1;
        send_word(rand_fill(), 1'b0);
        send_word(rand_fill(), 1'b1);

        test_block_kinds();
        test_skip_codes();
        test_chunk_end();
        test_register_limits();
        test_backpressure();
        test_random_frames();
        settle_block();

        if (rows_due.size() != 0) begin
            $error("%0d pixel rows never arrived", rows_due.size());
            fail_count++;
        end

        $display("Sent %0d frame words, checked %0d pixel rows, %0d size register writes",
                 words_sent, rows_seen, reg_writes);
        $display("Covered fill, two- and eight-colour blocks, skips, chunk ends, size limits");
        if (fail_count == 0) begin
            $display("PASS video1_block_decoder");
        end else begin
            $display("FAIL video1_block_decoder");
        end
        $finish;
    end

endmodule
